FILE: rtl/twrt_pkg.sv
// ============================================================================
// twrt_pkg: shared types and constants of the tooth wheel rpm tracker
// Field widths, arithmetic constants, register indexes and sequencer states.
// ============================================================================
package twrt_pkg;

    localparam int INTERVAL_W = 32;
    localparam int TEETH_W    = 6;
    localparam int TICK_W     = 10;
    localparam int GAP_W      = 10;
    localparam int BAND_W     = 16;
    localparam int RPM_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Teeth times tick, and the full rpm divisor.
    localparam int TT_W      = TEETH_W + TICK_W;
    localparam int DIVISOR_W = INTERVAL_W + TT_W;
    // Gap test products: interval times ratio, and (delta + 1) times 1000.
    localparam int GAP_PROD_W = INTERVAL_W + GAP_W;
    localparam int DELTA_W    = INTERVAL_W + 1;
    localparam int SCALED_W   = DELTA_W + GAP_W;

    localparam int NUM_W = 27;
    localparam logic [NUM_W-1:0]  RPM_NUM   = NUM_W'(120000000);
    localparam logic [RPM_W-1:0]  RPM_MAX   = {RPM_W{1'b1}};
    localparam logic [GAP_W-1:0]  GAP_SCALE = GAP_W'(1000);

    // Signed width for the filter compares: reference plus or minus a band.
    localparam int FILT_W = RPM_W + 2;

    localparam int CNT_W     = 5;
    localparam int MUL_STEPS = TT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEETH_PER_REV = 3'd0,
        CFG_TICK_US       = 3'd1,
        CFG_GAP_RATIO     = 3'd2,
        CFG_RESET_BAND    = 3'd3,
        CFG_HOLD_BAND     = 3'd4,
        CFG_MIN_RPM       = 3'd5,
        CFG_MAX_RPM       = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FILT = 4'b1000
    } t_state;

    // True when v lies more than band away from ref on either side.
    function automatic logic outside_band(
        input logic [RPM_W-1:0]  v,
        input logic [RPM_W-1:0]  ref_v,
        input logic [BAND_W-1:0] band
    );
        logic signed [FILT_W-1:0] sv;
        logic signed [FILT_W-1:0] sr;
        logic signed [FILT_W-1:0] sb;
        sv = $signed({2'b00, v});
        sr = $signed({2'b00, ref_v});
        sb = $signed({{(FILT_W-BAND_W){1'b0}}, band});
        return (sv > sr + sb) || (sv < sr - sb);
    endfunction

endpackage

FILE: rtl/tooth_wheel_rpm_tracker.sv
// ============================================================================
// tooth_wheel_rpm_tracker: crank wheel speed from tooth edge intervals
// Detects the missing-tooth gap or a full tooth count, computes rpm with a
// bit-serial divider and filters it against a kept reference speed.
// ============================================================================
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-------------------------------------
//  input   | i_in_valid / o_in_ready    | i_tooth_interval
//  output  | o_out_valid / i_out_ready  | o_rpm, o_sync, o_tooth_index
//  config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  After the accepting edge a request passes through S_MUL, shift-add
//  multiplication (one multiplier bit a cycle), then, only when a reference
//  point is found, S_DIV, restoring division (one quotient bit a cycle), and
//  last S_FILT, the filter cycle. A new request is accepted only once the
//  block is back in S_IDLE.
//  The result register is separate, so the next request is accepted while a
//  result waits; the filter cycle stalls until that register is free.
//  Reset is synchronous and active low and restores the register defaults.
//
module tooth_wheel_rpm_tracker
    import twrt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [INTERVAL_W-1:0]  i_tooth_interval,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [RPM_W-1:0]       o_rpm,
    output logic                   o_sync,
    output logic [TEETH_W-1:0]     o_tooth_index,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_state r_state;

    logic [TEETH_W-1:0] r_teeth;
    logic [TICK_W-1:0]  r_tick;
    logic [GAP_W-1:0]   r_gap;
    logic [BAND_W-1:0]  r_reset_band;
    logic [BAND_W-1:0]  r_hold_band;
    logic [RPM_W-1:0]   r_min_rpm;
    logic [RPM_W-1:0]   r_max_rpm;

    logic [INTERVAL_W-1:0] r_prev;
    logic [INTERVAL_W-1:0] r_delta;
    logic [TEETH_W-1:0]    r_count;
    logic [RPM_W-1:0]      r_ref;
    logic                  r_tracking;
    logic [RPM_W-1:0]      r_cur;

    // Shift-add multiplier operands and accumulators.
    logic [DIVISOR_W-1:0]  r_mp;
    logic [SCALED_W-1:0]   r_md;
    logic [TT_W-1:0]       r_mtt;
    logic [GAP_W-1:0]      r_mg;
    logic [GAP_W-1:0]      r_mk;
    logic [DIVISOR_W-1:0]  r_acc_pt;
    logic [GAP_PROD_W-1:0] r_acc_pg;
    logic [SCALED_W-1:0]   r_acc_d;
    logic [DIVISOR_W-1:0]  n_acc_pt;
    logic [GAP_PROD_W-1:0] n_acc_pg;
    logic [SCALED_W-1:0]   n_acc_d;

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_sync;
    logic                  r_zero;
    logic [NUM_W-1:0]      r_rem;
    logic [NUM_W-1:0]      r_quo;
    logic [RPM_W-1:0]      r_raw;

    logic                  r_out_valid;
    logic [RPM_W-1:0]      r_out_rpm;
    logic                  r_out_sync;
    logic [TEETH_W-1:0]    r_out_idx;

    logic                  in_accept;
    logic                  out_free;
    logic                  n_sync;
    logic [NUM_W:0]        div_trial;
    logic                  div_ge;
    logic [NUM_W-1:0]      n_rem;
    logic [NUM_W-1:0]      n_quo;
    logic [RPM_W-1:0]      n_raw;

    logic [RPM_W-1:0]      f_ref0;
    logic                  f_retake;
    logic [RPM_W-1:0]      f_ref1;
    logic                  f_hold;
    logic [RPM_W-1:0]      f_v1;
    logic [RPM_W-1:0]      f_v2;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_rpm         = r_out_rpm;
    assign o_sync        = r_out_sync;
    assign o_tooth_index = r_out_idx;

    // One multiplier bit per cycle for all three products.
    always_comb begin
        n_acc_pt = r_acc_pt;
        n_acc_pg = r_acc_pg;
        n_acc_d  = r_acc_d;
        if (r_mtt[0]) begin
            n_acc_pt = r_acc_pt + r_mp;
        end
        if (r_mg[0]) begin
            n_acc_pg = r_acc_pg + r_mp[GAP_PROD_W-1:0];
        end
        if (r_mk[0]) begin
            n_acc_d = r_acc_d + r_md;
        end
    end

    // Gap test: delta < floor(prev * ratio / 1000) is (delta + 1) * 1000 <= prev * ratio.
    assign n_sync = (n_acc_d <= {1'b0, n_acc_pg}) || (r_count == r_teeth);

    // Restoring division of the constant numerator, one quotient bit per cycle.
    assign div_trial = {r_rem, RPM_NUM[r_cnt]};
    assign div_ge    = {{(DIVISOR_W-NUM_W-1){1'b0}}, div_trial} >= r_acc_pt;
    assign n_rem     = div_ge ? NUM_W'(div_trial - r_acc_pt[NUM_W:0]) : div_trial[NUM_W-1:0];
    assign n_quo     = {r_quo[NUM_W-2:0], div_ge};
    assign n_raw     = (r_zero || (|n_quo[NUM_W-1:RPM_W])) ? RPM_MAX : n_quo[RPM_W-1:0];

    // Jump-reset and hold filter, then the plausibility range check.
    always_comb begin
        f_ref0   = r_tracking ? r_ref : r_raw;
        f_retake = outside_band(r_raw, f_ref0, r_reset_band);
        f_ref1   = f_retake ? r_raw : f_ref0;
        f_hold   = !f_retake && outside_band(r_raw, f_ref1, r_hold_band);
        f_v1     = f_hold ? f_ref1 : r_raw;
        f_v2     = ((f_v1 < r_min_rpm) || (f_v1 > r_max_rpm)) ? f_ref1 : f_v1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_teeth      <= TEETH_W'(12);
            r_tick       <= TICK_W'(50);
            r_gap        <= GAP_W'(700);
            r_reset_band <= BAND_W'(50);
            r_hold_band  <= BAND_W'(20);
            r_min_rpm    <= RPM_W'(100);
            r_max_rpm    <= RPM_W'(4000);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEETH_PER_REV: r_teeth      <= i_cfg_data[TEETH_W-1:0];
                CFG_TICK_US:       r_tick       <= i_cfg_data[TICK_W-1:0];
                CFG_GAP_RATIO:     r_gap        <= i_cfg_data[GAP_W-1:0];
                CFG_RESET_BAND:    r_reset_band <= i_cfg_data[BAND_W-1:0];
                CFG_HOLD_BAND:     r_hold_band  <= i_cfg_data[BAND_W-1:0];
                CFG_MIN_RPM:       r_min_rpm    <= i_cfg_data[RPM_W-1:0];
                CFG_MAX_RPM:       r_max_rpm    <= i_cfg_data[RPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_count     <= '0;
            r_ref       <= '0;
            r_tracking  <= 1'b0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_sync      <= 1'b0;
        end else begin
            // The filter cycle loads the result register itself when it is free.
            if (i_out_ready && (r_state != S_FILT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_delta  <= i_tooth_interval;
                        r_mp     <= DIVISOR_W'(r_prev);
                        r_md     <= SCALED_W'({1'b0, i_tooth_interval} + DELTA_W'(1));
                        r_mtt    <= TT_W'(r_teeth) * TT_W'(r_tick);
                        r_mg     <= r_gap;
                        r_mk     <= GAP_SCALE;
                        r_acc_pt <= '0;
                        r_acc_pg <= '0;
                        r_acc_d  <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc_pt <= n_acc_pt;
                    r_acc_pg <= n_acc_pg;
                    r_acc_d  <= n_acc_d;
                    r_mp     <= {r_mp[DIVISOR_W-2:0], 1'b0};
                    r_md     <= {r_md[SCALED_W-2:0], 1'b0};
                    r_mtt    <= {1'b0, r_mtt[TT_W-1:1]};
                    r_mg     <= {1'b0, r_mg[GAP_W-1:1]};
                    r_mk     <= {1'b0, r_mk[GAP_W-1:1]};
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_sync <= n_sync;
                        r_zero <= (n_acc_pt == '0);
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_cnt  <= CNT_W'(NUM_W - 1);
                        r_state <= n_sync ? S_DIV : S_FILT;
                    end else begin
                        r_cnt  <= r_cnt + CNT_W'(1);
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_raw   <= n_raw;
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sync  <= r_sync;
                        r_prev      <= r_delta;
                        if (r_sync) begin
                            r_ref      <= f_ref1;
                            r_tracking <= !f_retake;
                            r_cur      <= f_v2;
                            r_count    <= TEETH_W'(1);
                            r_out_rpm  <= f_v2;
                            r_out_idx  <= TEETH_W'(1);
                        end else begin
                            r_count    <= r_count + TEETH_W'(1);
                            r_out_rpm  <= r_cur;
                            r_out_idx  <= r_count + TEETH_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A reference point always restarts the tooth count at one.
    a_sync_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sync) |-> (o_tooth_index == TEETH_W'(1)))
        else $error("reference point result with tooth index other than one");

    // Only one request is in flight at a time.
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input accepted while a request is still in work");

    // The divider runs only for reference points.
    a_div_on_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_sync)
        else $error("rpm division started without a reference point");
`endif

endmodule

FILE: tb/tooth_wheel_rpm_tracker_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tooth_wheel_rpm_tracker_tb: self-checking bench for the crank wheel tracker
// A queue-fed driver sends tooth intervals, a scoreboard predicts each reading
// (sync, tooth index, filtered rpm) and a monitor compares every result field.
// Settings change between phases while the block is idle.
// ============================================================================
module tooth_wheel_rpm_tracker_tb;
    import twrt_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 60;
    localparam longint unsigned SPEED_NUM = 64'd120000000;

    typedef struct packed {
        logic [RPM_W-1:0]   rpm;
        logic               sync;
        logic [TEETH_W-1:0] index;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [INTERVAL_W-1:0] i_tooth_interval = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [RPM_W-1:0]      o_rpm;
    logic                  o_sync;
    logic [TEETH_W-1:0]    o_tooth_index;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_TEETH_PER_REV;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tooth_wheel_rpm_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_tooth_interval(i_tooth_interval),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rpm           (o_rpm),
        .o_sync          (o_sync),
        .o_tooth_index   (o_tooth_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Settings as the block should hold them.
    logic [TEETH_W-1:0] teeth_cfg = 6'd12;
    logic [TICK_W-1:0]  tick_cfg  = 10'd50;
    logic [GAP_W-1:0]   gap_cfg   = 10'd700;
    logic [BAND_W-1:0]  reset_cfg = 16'd50;
    logic [BAND_W-1:0]  hold_cfg  = 16'd20;
    logic [RPM_W-1:0]   min_cfg   = 20'd100;
    logic [RPM_W-1:0]   max_cfg   = 20'd4000;

    // Tracker state as predicted.
    logic [INTERVAL_W-1:0] prev_iv    = '0;
    logic [TEETH_W-1:0]    tooth_cnt  = '0;
    logic [RPM_W-1:0]      anchor_rpm = '0;
    logic                  locked     = 1'b0;
    logic [RPM_W-1:0]      shown_rpm  = '0;

    logic [INTERVAL_W-1:0] tooth_q [$];
    t_reading              expected_readings [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_go = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int bad_fields = 0;
    int teeth_sent = 0;
    int readings_seen = 0;
    int syncs_seen = 0;
    int reg_writes = 0;
    int settings_used = 1;

    function automatic logic [RPM_W-1:0] speed_from_interval(input logic [INTERVAL_W-1:0] iv);
        logic [63:0] divisor;
        logic [63:0] quot;
        divisor = 64'(iv) * 64'(teeth_cfg) * 64'(tick_cfg);
        if (divisor == 0) begin
            return RPM_MAX;
        end
        quot = SPEED_NUM / divisor;
        return (quot > 64'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];
    endfunction

    // Signed compare, so the lower edge of the band may go below zero.
    function automatic logic beyond_band(input logic [RPM_W-1:0] v,
                                         input logic [RPM_W-1:0] anchor,
                                         input logic [BAND_W-1:0] band);
        longint sv;
        longint sa;
        longint sb;
        sv = v;
        sa = anchor;
        sb = band;
        return (sv > sa + sb) || (sv < sa - sb);
    endfunction

    function automatic void predict_tooth(input logic [INTERVAL_W-1:0] iv);
        logic [63:0]      gap_limit;
        logic             hit;
        logic [RPM_W-1:0] r;
        t_reading         res;
        gap_limit = (64'(prev_iv) * 64'(gap_cfg)) / 64'd1000;
        hit = (64'(iv) < gap_limit) || (tooth_cnt == teeth_cfg);
        if (hit) begin
            r = speed_from_interval(prev_iv);
            if (!locked) begin
                anchor_rpm = r;
                locked = 1'b1;
            end
            if (locked && beyond_band(r, anchor_rpm, reset_cfg)) begin
                locked = 1'b0;
                anchor_rpm = r;
            end
            if (locked && beyond_band(r, anchor_rpm, hold_cfg)) begin
                r = anchor_rpm;
            end
            if (r < min_cfg || r > max_cfg) begin
                r = anchor_rpm;
            end
            shown_rpm = r;
            tooth_cnt = 6'd1;
        end else begin
            tooth_cnt = tooth_cnt + 6'd1;
        end
        prev_iv = iv;
        res.rpm = shown_rpm;
        res.sync = hit;
        res.index = tooth_cnt;
        expected_readings.push_back(res);
    endfunction

    // Driver: presents the next pending interval, keeps it steady until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_tooth_interval <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_tooth(i_tooth_interval);
                teeth_sent <= teeth_sent + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tooth_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_tooth_interval <= tooth_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: every accepted result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_reading want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                readings_seen <= readings_seen + 1;
                if (o_sync) begin
                    syncs_seen <= syncs_seen + 1;
                end
                if (expected_readings.size() == 0) begin
                    $error("unexpected result: rpm %0d, sync %0d, tooth_index %0d",
                           o_rpm, o_sync, o_tooth_index);
                    errs++;
                end else begin
                    want = expected_readings.pop_front();
                    if (o_rpm !== want.rpm) begin
                        $error("rpm: expected %0d, actual %0d", want.rpm, o_rpm);
                        errs++;
                    end
                    if (o_sync !== want.sync) begin
                        $error("sync: expected %0d, actual %0d", want.sync, o_sync);
                        errs++;
                    end
                    if (o_tooth_index !== want.index) begin
                        $error("tooth_index: expected %0d, actual %0d",
                               want.index, o_tooth_index);
                        errs++;
                    end
                end
                bad_fields <= bad_fields + errs;
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (tooth_q.size() != 0 || i_in_valid || expected_readings.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_TEETH_PER_REV: teeth_cfg = data[TEETH_W-1:0];
            CFG_TICK_US:       tick_cfg  = data[TICK_W-1:0];
            CFG_GAP_RATIO:     gap_cfg   = data[GAP_W-1:0];
            CFG_RESET_BAND:    reset_cfg = data[BAND_W-1:0];
            CFG_HOLD_BAND:     hold_cfg  = data[BAND_W-1:0];
            CFG_MIN_RPM:       min_cfg   = data[RPM_W-1:0];
            CFG_MAX_RPM:       max_cfg   = data[RPM_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] teeth, tick, gap,
                                 input logic [CFG_DATA_W-1:0] rband, hband, lo, hi);
        write_reg(CFG_TEETH_PER_REV, teeth);
        write_reg(CFG_TICK_US, tick);
        write_reg(CFG_GAP_RATIO, gap);
        write_reg(CFG_RESET_BAND, rband);
        write_reg(CFG_HOLD_BAND, hband);
        write_reg(CFG_MIN_RPM, lo);
        write_reg(CFG_MAX_RPM, hi);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Base interval that puts the computed speed somewhere around 50..6000 rpm.
    function automatic longint pick_base(input int teeth);
        longint per_tick;
        longint b;
        per_tick = longint'(teeth) * longint'(tick_cfg);
        if (per_tick == 0) begin
            return longint'($urandom_range(2000, 1));
        end
        b = 120000000 / (longint'($urandom_range(6000, 50)) * per_tick);
        return (b < 1) ? 1 : b;
    endfunction

    // Mostly whole revolutions with a drifting base speed, some stray intervals.
    task automatic queue_teeth(input int n_items);
        int     teeth;
        int     per_rev;
        int     made;
        int     k;
        longint base;
        longint step;
        teeth = (teeth_cfg == 0) ? 64 : int'(teeth_cfg);
        per_rev = (teeth > 1) ? teeth - 1 : 1;
        base = pick_base(teeth);
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(99) < 20) begin
                case ($urandom_range(3))
                    0: tooth_q.push_back($urandom);
                    1: tooth_q.push_back('0);
                    2: tooth_q.push_back('1);
                    default: tooth_q.push_back(INTERVAL_W'($urandom_range(64, 1)));
                endcase
                made++;
            end else begin
                if ($urandom_range(7) == 0) begin
                    base = pick_base(teeth);
                end else begin
                    step = base / 16 + 1;
                    base = base + longint'($urandom_range(int'(2 * step))) - step;
                    if (base < 1) begin
                        base = 1;
                    end
                end
                for (k = 0; k < per_rev; k++) begin
                    // The last interval spans the missing tooth.
                    if (teeth > 2 && k == teeth - 2) begin
                        tooth_q.push_back(INTERVAL_W'(base * $urandom_range(3, 2)));
                    end else begin
                        tooth_q.push_back(INTERVAL_W'(base + $urandom_range(int'(base / 32))));
                    end
                    made++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] teeth, tick, gap,
                             input logic [CFG_DATA_W-1:0] rband, hband, lo, hi,
                             input int n_items, input logic with_hold);
        load_settings(teeth, tick, gap, rband, hband, lo, hi);
        @(negedge i_clk);
        queue_teeth(n_items);
        if (with_hold) begin
            // Stop taking results for a long stretch while the driver keeps sending.
            @(posedge i_clk);
            hold_go <= 1'b1;
            @(posedge i_clk);
            hold_go <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin : stimulus
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct <= 9;
        rx_idle_pct <= 46;

        // Reset settings: extreme intervals, a zero divisor reached by tooth
        // count, a gap sync, a held reading and a retaken reference.
        @(negedge i_clk);
        tooth_q = '{32'd0, 32'hFFFF_FFFF, 32'd0,
                    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                    32'd400, 32'd200, 32'd205, 32'd210, 32'd420, 32'd100, 32'd1,
                    32'h8000_0000, 32'h7FFF_FFFF};
        wait_drained();

        // One tooth per revolution and a unit tick: the quotient saturates.
        load_settings(20'd1, 20'd1, 20'd700, 20'd50, 20'd20, 20'd0, 20'hFFFFF);
        @(negedge i_clk);
        tooth_q = '{32'd1, 32'd1, 32'd2, 32'd100, 32'd0, 32'd5};
        wait_drained();

        run_phase(20'd12, 20'd50, 20'd700, 20'd50, 20'd20, 20'd100, 20'd4000, 220, 1'b0);
        run_phase(20'd36, 20'd10, 20'd500, 20'd200, 20'd30, 20'd0, 20'hFFFFF, 220, 1'b0);

        tx_idle_pct <= 46;
        rx_idle_pct <= 9;
        run_phase(20'd63, 20'd1023, 20'd1000, 20'd0, 20'd0, 20'd500, 20'd3000, 200, 1'b0);
        // Tooth count of zero (upper data bits dropped), no gap detection,
        // widest bands and a range that nothing passes.
        run_phase(20'hFFFC0, 20'd1, 20'd0, 20'd65535, 20'd65535, 20'hFFFFF, 20'd0,
                  180, 1'b0);
        // Tick of zero after masking: every computed speed saturates.
        run_phase(20'd4, 20'hFFC00, 20'd1023, 20'd100, 20'd50, 20'd0, 20'hFFFFF, 100, 1'b0);

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        for (k = 0; k < 5; k++) begin
            run_phase(CFG_DATA_W'($urandom_range(63, 1)), CFG_DATA_W'($urandom_range(1023, 1)),
                      CFG_DATA_W'($urandom_range(950, 300)), CFG_DATA_W'($urandom_range(400)),
                      CFG_DATA_W'($urandom_range(200)), CFG_DATA_W'($urandom_range(1000)),
                      CFG_DATA_W'($urandom_range(20000, 2000)), 140, k == 0);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d tooth edges and %0d checked readings, %0d of them syncs.",
                 teeth_sent, readings_seen, syncs_seen);
        $display("Settings used: %0d (%0d register writes), including zero and full-scale.",
                 settings_used, reg_writes);
        if (bad_fields == 0 && expected_readings.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
